@@ rtl/dsi_pkg.sv @@
// Package for the decimal string to integer converter.
// Holds character codes, register indexes and the shared parse types.
// No dependencies.
`default_nettype none

package dsi_pkg;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Width of the result value field and of the channel words
  localparam int unsigned VALUE_OUT_W = 64;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIGNED_MODE = 8'd0,
    CFG_PERMISSIVE  = 8'd1
  } cfg_idx_t;

  // Configuration settings seen by the parser
  typedef struct packed {
    logic signed_mode;
    logic permissive;
  } cfg_t;

  // Parse flags kept between bytes
  typedef struct packed {
    logic negative;
    logic at_start;
    logic digit_seen;
    logic stopped;
    logic failed;
  } parse_flags_t;

  localparam parse_flags_t FLAGS_CLEAR = '{
    negative:   1'b0,
    at_start:   1'b1,
    digit_seen: 1'b0,
    stopped:    1'b0,
    failed:     1'b0
  };

  // One result beat
  typedef struct packed {
    logic [VALUE_OUT_W-1:0] value;
    logic                   valid_res;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/dsi_step.sv @@
// Per-byte parse step: next accumulator and flags, and the result on a terminator.
// Purely combinational; depends on dsi_pkg.
`default_nettype none

module dsi_step #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic [dsi_pkg::CHAR_W-1:0] ch,
  input  wire dsi_pkg::cfg_t              cfg,
  input  wire dsi_pkg::parse_flags_t      flags,
  input  wire logic [VALUE_WIDTH-1:0]     acc,
  output dsi_pkg::parse_flags_t           flags_nxt,
  output logic [VALUE_WIDTH-1:0]          acc_nxt,
  output logic                            term,
  output dsi_pkg::result_t                result
);

  logic [3:0]                 digit;
  logic                       is_digit;
  logic [VALUE_WIDTH-1:0]     acc_x8;
  logic [VALUE_WIDTH-1:0]     acc_x2;
  logic [VALUE_WIDTH-1:0]     acc_dec;
  logic [VALUE_WIDTH-1:0]     signed_v;
  logic                       ok;

  // Decode the byte and form acc*10 + digit as two shifts and two adds
  always_comb begin
    digit    = 4'(ch - dsi_pkg::CH_ZERO);
    is_digit = (ch >= dsi_pkg::CH_ZERO) && (ch <= dsi_pkg::CH_NINE);
    acc_x8   = {acc[VALUE_WIDTH-4:0], 3'b000};
    acc_x2   = {acc[VALUE_WIDTH-2:0], 1'b0};
    acc_dec  = acc_x8 + acc_x2 + VALUE_WIDTH'(digit);
    term     = (ch == dsi_pkg::CH_NUL);
  end

  // Build the result from the state before the terminator
  always_comb begin
    ok       = flags.digit_seen && !flags.failed;
    signed_v = flags.negative ? ('0 - acc) : acc;
    result.value     = '0;
    result.valid_res = ok;
    if (ok) begin
      result.value[VALUE_WIDTH-1:0] = signed_v;
    end
  end

  // Advance the parse state
  always_comb begin
    flags_nxt = flags;
    acc_nxt   = acc;
    if (term) begin
      flags_nxt = dsi_pkg::FLAGS_CLEAR;
      acc_nxt   = '0;
    end else if (flags.failed || flags.stopped) begin
      // drop bytes until the terminator
    end else if (flags.at_start && (ch == dsi_pkg::CH_MINUS) && cfg.signed_mode) begin
      flags_nxt.negative = 1'b1;
      flags_nxt.at_start = 1'b0;
    end else begin
      flags_nxt.at_start = 1'b0;
      if (is_digit) begin
        acc_nxt              = acc_dec;
        flags_nxt.digit_seen = 1'b1;
      end else if (cfg.permissive && flags.digit_seen) begin
        flags_nxt.stopped = 1'b1;
      end else begin
        flags_nxt.failed = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/decimal_string_to_integer.sv @@
// Top level of the streaming decimal string to integer converter.
// Parse state registers, configuration registers and a two-deep result buffer.
// Depends on dsi_pkg and dsi_step.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in_     | sink      | in_tvalid / in_tready  | tdata: char_code[7:0]
//   out_    | source    | out_tvalid / out_tready| tdata: value[63:0]; tuser: valid_res
//   cfg_    | sink      | cfg_valid / cfg_ready  | cfg_index[7:0], cfg_data[7:0] (bit 0)
//
// One byte is taken every cycle while in_tready is high; the multiply-by-ten add
// updates the accumulator register in the cycle the byte is accepted. The result
// of a terminator goes to the output register, or to the skid register while the
// output is held, so input flows while a result waits; in_tready drops only when
// both hold results. rst_n is synchronous, active low; cfg_ready is always high.
`default_nettype none

module decimal_string_to_integer #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // tdata: char_code[7:0]
  input  wire logic [dsi_pkg::CHAR_W-1:0]       in_tdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // tdata: value[63:0]
  output logic [dsi_pkg::VALUE_OUT_W-1:0]       out_tdata,
  // tuser: valid_res[0]
  output logic [0:0]                            out_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic [dsi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dsi_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready
);

  dsi_pkg::cfg_t         cfg_r;
  dsi_pkg::parse_flags_t flags_r;
  dsi_pkg::parse_flags_t flags_nxt;
  logic [VALUE_WIDTH-1:0] acc_r;
  logic [VALUE_WIDTH-1:0] acc_nxt;
  logic                   term;
  dsi_pkg::result_t       result;

  dsi_pkg::result_t out_r;
  logic             out_valid_r;
  dsi_pkg::result_t skid_r;
  logic             skid_valid_r;

  logic in_beat;
  logic push;
  logic pop;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign in_beat   = in_tvalid && in_tready;
  assign push      = in_beat && term;
  assign pop       = out_valid_r && out_tready;

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_r.value;
  assign out_tuser[0] = out_r.valid_res;

  dsi_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_step (
    .ch        (in_tdata),
    .cfg       (cfg_r),
    .flags     (flags_r),
    .acc       (acc_r),
    .flags_nxt (flags_nxt),
    .acc_nxt   (acc_nxt),
    .term      (term),
    .result    (result)
  );

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.signed_mode <= 1'b1;
      cfg_r.permissive  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dsi_pkg::CFG_SIGNED_MODE: cfg_r.signed_mode <= cfg_data[0];
        dsi_pkg::CFG_PERMISSIVE:  cfg_r.permissive  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance parse state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= dsi_pkg::FLAGS_CLEAR;
      acc_r   <= '0;
    end else if (in_beat) begin
      flags_r <= flags_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Result buffer control: output register first, skid when it is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Result buffer payload
  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= result;
      end
    end else if (push) begin
      skid_r <= result;
    end
  end

  // The skid register is only filled behind a held output
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while output register is empty");

  // A failed parse always reports a zero value
  a_invalid_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.valid_res) |-> (out_r.value == '0))
    else $error("invalid result carries a nonzero value");

  // A terminator clears the parse state for the next string
  a_term_clears : assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (flags_r == dsi_pkg::FLAGS_CLEAR) && (acc_r == '0))
    else $error("parse state not cleared after terminator");

  // A terminator beat always lands in the buffer by the next cycle
  a_push_lands : assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid_r)
    else $error("result of terminator beat lost");

endmodule

`default_nettype wire
